@@ rtl/wsfd_pkg.sv @@
`default_nettype none

package wsfd_pkg;

  localparam logic [2:0] KIND_DATA       = 3'd0;
  localparam logic [2:0] KIND_PONG       = 3'd1;
  localparam logic [2:0] KIND_EMPTY_DATA = 3'd2;
  localparam logic [2:0] KIND_EMPTY_PING = 3'd3;
  localparam logic [2:0] KIND_CLOSE      = 3'd4;

  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  localparam int unsigned LimitW = 21;
  localparam logic [LimitW-1:0] MAX_DELIVERED_RESET = 21'd4096;

  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [3:0]  opcode;
    logic [31:0] length;
    logic        last;
    logic        truncated;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/wsfd_parser.sv @@
`default_nettype none

module wsfd_parser #(
  parameter int unsigned PING_ECHO_MAX = 125
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic [7:0]                    rx_byte_i,
  input  wire logic [wsfd_pkg::LimitW-1:0]   max_delivered_i,
  output wsfd_pkg::result_t                  result_o
);

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_PAY  = 3'd4;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [2:0] CNT_EXT16  = 3'd2;
  localparam logic [2:0] CNT_EXT64  = 3'd0;
  localparam logic [2:0] CNT_KEY    = 3'd4;
  localparam logic [31:0] PING_LIM  = 32'(PING_ECHO_MAX);

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        masked_q, masked_d;
  logic [31:0] len_q, len_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] key_q, key_d;
  logic [31:0] pos_q, pos_d;

  logic                        hdr_done;
  logic [6:0]                  len7;
  logic [7:0]                  key_byte;
  logic [7:0]                  plain;
  logic [31:0]                 pos_inc;
  logic [wsfd_pkg::LimitW-1:0] data_lim;
  logic [31:0]                 data_lim_w;
  logic [31:0]                 lim;
  wsfd_pkg::result_t           res;

  assign len7       = rx_byte_i[6:0];
  assign pos_inc    = pos_q + 32'd1;
  assign data_lim   = (max_delivered_i == '0) ? wsfd_pkg::LimitW'(1) : max_delivered_i;
  assign data_lim_w = 32'(data_lim);

  always_comb begin
    case (pos_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign plain = rx_byte_i ^ key_byte;

  always_comb begin
    phase_d       = phase_q;
    opcode_d      = opcode_q;
    masked_d      = masked_q;
    len_d         = len_q;
    cnt_d         = cnt_q;
    key_d         = key_q;
    pos_d         = pos_q;
    hdr_done      = 1'b0;
    lim           = '0;
    res           = '0;
    case (phase_q)
      PH_HDR1: begin
        masked_d = rx_byte_i[7];
        key_d    = '0;
        if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
          len_d   = '0;
          cnt_d   = (len7 == LEN7_EXT16) ? CNT_EXT16 : CNT_EXT64;
          phase_d = PH_EXT;
        end else begin
          len_d = 32'(len7);
          if (rx_byte_i[7]) begin
            cnt_d   = CNT_KEY;
            phase_d = PH_KEY;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      PH_EXT: begin
        len_d = {len_q[23:0], rx_byte_i};
        cnt_d = cnt_q - 3'd1;
        if (cnt_d == '0) begin
          if (masked_q) begin
            cnt_d   = CNT_KEY;
            phase_d = PH_KEY;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      PH_KEY: begin
        key_d = {key_q[23:0], rx_byte_i};
        cnt_d = cnt_q - 3'd1;
        if (cnt_d == '0) begin
          hdr_done = 1'b1;
        end
      end
      PH_PAY: begin
        if (pos_inc == len_q) begin
          phase_d = PH_HDR0;
        end
        pos_d = pos_inc;
        if (opcode_q == wsfd_pkg::OP_PING) begin
          lim = (len_q < PING_LIM) ? len_q : PING_LIM;
          if (pos_q < lim) begin
            res.valid = 1'b1;
            res.kind  = wsfd_pkg::KIND_PONG;
            res.data  = plain;
            res.last  = (pos_inc == lim);
          end
        end else if (opcode_q != wsfd_pkg::OP_CLOSE) begin
          lim = (len_q < data_lim_w) ? len_q : data_lim_w;
          if (pos_q < lim) begin
            res.valid     = 1'b1;
            res.kind      = wsfd_pkg::KIND_DATA;
            res.data      = plain;
            res.last      = (pos_inc == lim);
            res.truncated = (len_q > data_lim_w);
          end
        end
      end
      default: begin
        opcode_d = rx_byte_i[3:0];
        phase_d  = PH_HDR1;
      end
    endcase

    if (hdr_done) begin
      pos_d   = '0;
      phase_d = (len_d == '0) ? PH_HDR0 : PH_PAY;
      if (opcode_q == wsfd_pkg::OP_CLOSE) begin
        res.valid = 1'b1;
        res.kind  = wsfd_pkg::KIND_CLOSE;
        res.last  = 1'b1;
      end else if (len_d == '0) begin
        res.valid = 1'b1;
        res.kind  = (opcode_q == wsfd_pkg::OP_PING) ? wsfd_pkg::KIND_EMPTY_PING
                                                    : wsfd_pkg::KIND_EMPTY_DATA;
        res.last  = 1'b1;
      end
    end

    res.opcode = opcode_q;
    res.length = len_d;
    res.valid  = res.valid & step_i;
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      opcode_q <= '0;
      masked_q <= 1'b0;
      len_q    <= '0;
      cnt_q    <= '0;
      key_q    <= '0;
      pos_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      masked_q <= masked_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      key_q    <= key_d;
      pos_q    <= pos_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/websocket_frame_deframer_unit.sv @@
// WebSocket receive-side frame parser.
// Input channel: one received byte per transfer on rx_byte_i (in_valid_i / in_ready_o).
// Output channel: one result per transfer (out_valid_o / out_ready_i) with kind,
//   unmasked payload byte, frame opcode, 32-bit frame length, last and truncated.
// Header bytes give no result; the byte completing a header may give one event
//   (empty data frame, empty ping or close). Payload bytes give data or pong bytes.
// Configuration: cfg_we_i writes cfg_wdata_i into the delivery limit;
//   write only while the block is idle.
// Throughput: one byte per cycle while in_ready_o is high. A result appears in
//   the cycle after its byte's transfer, held in a single output register.
// When the receiver stalls, the output register holds its result and in_ready_o
//   drops until it is taken; it rises again in the cycle out_ready_i is high.
// Reset: the parser expects header byte zero, the output register is empty and
//   the delivery limit returns to 4096.
`default_nettype none

module websocket_frame_deframer_unit #(
  parameter int unsigned PING_ECHO_MAX = 125
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [wsfd_pkg::LimitW-1:0] cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [7:0]                  rx_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [2:0]                       result_kind_o,
  output logic [7:0]                       payload_byte_o,
  output logic [3:0]                       frame_opcode_o,
  output logic [31:0]                      frame_length_o,
  output logic                             last_o,
  output logic                             truncated_o
);

  logic [wsfd_pkg::LimitW-1:0] max_delivered_q;
  logic                        out_valid_q;
  wsfd_pkg::result_t           res;
  wsfd_pkg::result_t           res_q;
  logic                        in_xfer;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  wsfd_parser #(
    .PING_ECHO_MAX(PING_ECHO_MAX)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (in_xfer),
    .rx_byte_i      (rx_byte_i),
    .max_delivered_i(max_delivered_q),
    .result_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_delivered_q <= wsfd_pkg::MAX_DELIVERED_RESET;
    end else if (cfg_we_i) begin
      max_delivered_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= res.valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && res.valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = res_q.kind;
  assign payload_byte_o = res_q.data;
  assign frame_opcode_o = res_q.opcode;
  assign frame_length_o = res_q.length;
  assign last_o         = res_q.last;
  assign truncated_o    = res_q.truncated;

`ifndef ASSERT_OFF
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result stalled");

  a_trunc_only_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && truncated_o |-> result_kind_o == wsfd_pkg::KIND_DATA)
    else $error("truncated flag on non-data result");

  a_event_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == wsfd_pkg::KIND_EMPTY_DATA ||
    result_kind_o == wsfd_pkg::KIND_EMPTY_PING ||
    result_kind_o == wsfd_pkg::KIND_CLOSE) |-> last_o && payload_byte_o == 8'd0)
    else $error("event result not last or carries data");

  a_result_follows_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(in_xfer) && !$past(out_valid_o) |-> !out_valid_o)
    else $error("result without input transfer");
`endif

endmodule

`default_nettype wire
